[rtl/line_aware_substring_matcher_macros.svh]
// Assertion macros for the line-aware substring matcher.
// Used by the top level; clock and reset names are those of its ports.
`ifndef LINE_AWARE_SUBSTRING_MATCHER_MACROS_SVH
`define LINE_AWARE_SUBSTRING_MATCHER_MACROS_SVH
`ifndef SYNTHESIS
`define LASM_ASSERT(label, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("lasm: assertion failed");
`define LASM_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("lasm: assertion failed");
`else
`define LASM_ASSERT(label, expr)
`define LASM_ASSERT_NEXT(label, pre, post)
`endif
`endif

[rtl/lasm_pkg.sv]
// Shared types, constants, byte classification and case folding for the substring matcher.
// No dependencies.
`default_nettype none
package lasm_pkg;
    localparam int MAX_PAT   = 16;
    localparam int POS_BITS  = 32;
    localparam int LEN_BITS  = 5;
    localparam int IDX_BITS  = 4;

    localparam logic [7:0]  LINE_FEED       = 8'h0A;
    localparam logic [7:0]  CARRIAGE_RET    = 8'h0D;
    localparam logic [7:0]  UNDERSCORE      = 8'h5F;
    localparam logic [15:0] HIT_LIMIT_RESET = 16'd20001;

    localparam logic [2:0] CFG_PAT_LO    = 3'd0;
    localparam logic [2:0] CFG_PAT_HI    = 3'd1;
    localparam logic [2:0] CFG_PAT_LEN   = 3'd2;
    localparam logic [2:0] CFG_MATCH_CASE = 3'd3;
    localparam logic [2:0] CFG_WHOLE_WORD = 3'd4;
    localparam logic [2:0] CFG_HIT_LIMIT = 3'd5;

    localparam logic KIND_HIT  = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    typedef logic [MAX_PAT-1:0][7:0] t_window;

    typedef struct packed {
        logic hit;
        logic before_is_word;
    } t_win_result;

    typedef struct packed {
        logic        kind;
        logic [31:0] line;
        logic [31:0] start_off;
        logic [31:0] end_off;
        logic [15:0] hits;
        logic        last;
    } t_res;

    function automatic logic is_word(input logic [7:0] c);
        logic w;
        w = (c inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39]}) || (c == UNDERSCORE);
        return w;
    endfunction

    function automatic logic [7:0] fold(input logic [7:0] c, input logic exact);
        logic [7:0] r;
        r = c;
        if (!exact && (c inside {[8'h41:8'h5A]})) begin
            r = c | 8'h20;
        end
        return r;
    endfunction
endpackage
`default_nettype wire

[rtl/lasm_window.sv]
// Parallel compare of the 16-byte text window against the pattern.
// Depends on lasm_pkg.
`default_nettype none
module lasm_window (
    input  wire logic [7:0]                      i_byte,
    input  wire lasm_pkg::t_window               i_recent,
    input  wire logic [127:0]                    i_pattern,
    input  wire logic [lasm_pkg::LEN_BITS-1:0]   i_len,
    input  wire logic                            i_exact,
    output lasm_pkg::t_win_result                o_result
);
    import lasm_pkg::*;

    logic [MAX_PAT-1:0] lane_ok;

    // lane j holds the byte j places back from the newest; it meets pattern byte len-1-j
    always_comb begin
        for (int j = 0; j < MAX_PAT; j++) begin
            logic [LEN_BITS-1:0] pidx;
            logic [7:0]          pbyte;
            logic [7:0]          tbyte;
            pidx  = i_len - LEN_BITS'(j + 1);
            pbyte = i_pattern[pidx[IDX_BITS-1:0]*8 +: 8];
            tbyte = (j == 0) ? i_byte : i_recent[(j == 0) ? 0 : j - 1];
            if (LEN_BITS'(j) >= i_len) begin
                lane_ok[j] = 1'b1;
            end else begin
                lane_ok[j] = (fold(tbyte, i_exact) == fold(pbyte, i_exact));
            end
        end
    end

    logic [LEN_BITS-1:0] before_idx;
    assign before_idx = i_len - LEN_BITS'(1);

    assign o_result = '{hit: &lane_ok,
                        before_is_word: is_word(i_recent[before_idx[IDX_BITS-1:0]])};
endmodule
`default_nettype wire

[rtl/line_aware_substring_matcher.sv]
// Line-aware substring matcher, top level: input stage, stream state, result queue.
// Depends on lasm_pkg, lasm_window and line_aware_substring_matcher_macros.svh.
//
// Takes one text byte per cycle while the input register is not held, and
// reports non-overlapping pattern hits as line number, start offset and end
// offset, then a done item (tuser set) with the text length and hit count on
// the byte flagged tlast. Each byte passes an input register and is evaluated
// combinationally into a three-entry result queue. A byte that causes no
// result never waits. A byte that causes results waits in the input register
// until the queue is empty or empties in that cycle, so with the result port
// always ready one result per byte still flows every cycle, and a byte with
// two or three results holds the next result-causing byte until its extra
// results have gone out. The configuration port is always ready and must be
// written only while the stream is idle.
`default_nettype none
`include "line_aware_substring_matcher_macros.svh"
module line_aware_substring_matcher (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [7:0]   s_axis_tdata,   // [7:0] text_byte
    input  wire logic         s_axis_tlast,   // end_of_text
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [111:0]      m_axis_tdata,   // line_number, start_offset, end_offset, hits
    output logic              m_axis_tuser,   // item_kind
    output logic              m_axis_tlast,   // last_of_run
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [2:0]   i_cfg_index,
    input  wire logic [63:0]  i_cfg_data
);
    import lasm_pkg::*;

    // configuration
    logic [63:0]         r_pat_lo, r_pat_hi;
    logic [LEN_BITS-1:0] r_pat_len;
    logic                r_exact, r_whole_word;
    logic [15:0]         r_hit_limit;

    // input stage
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_eot;

    // stream state
    t_window               r_recent;
    logic [POS_BITS-1:0]   r_pos;
    logic [31:0]           r_line;
    logic [LEN_BITS-1:0]   r_seen;
    logic [POS_BITS-1:0]   r_earliest;
    logic                  r_pend_valid;
    logic [POS_BITS-1:0]   r_pend_start;
    logic [15:0]           r_hits;

    // result queue
    t_res       r_q [3];
    logic [1:0] r_cnt;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo     <= '0;
            r_pat_hi     <= '0;
            r_pat_len    <= LEN_BITS'(1);
            r_exact      <= 1'b0;
            r_whole_word <= 1'b0;
            r_hit_limit  <= HIT_LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_PAT_LO:     r_pat_lo     <= i_cfg_data;
                CFG_PAT_HI:     r_pat_hi     <= i_cfg_data;
                CFG_PAT_LEN:    r_pat_len    <= i_cfg_data[LEN_BITS-1:0];
                CFG_MATCH_CASE: r_exact      <= i_cfg_data[0];
                CFG_WHOLE_WORD: r_whole_word <= i_cfg_data[0];
                CFG_HIT_LIMIT:  r_hit_limit  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // effective pattern length, 1..16
    logic [LEN_BITS-1:0] len;
    always_comb begin
        if (r_pat_len == '0) begin
            len = LEN_BITS'(1);
        end else if (r_pat_len > LEN_BITS'(MAX_PAT)) begin
            len = LEN_BITS'(MAX_PAT);
        end else begin
            len = r_pat_len;
        end
    end

    t_win_result win;
    lasm_window u_window (
        .i_byte    (r_in_byte),
        .i_recent  (r_recent),
        .i_pattern ({r_pat_hi, r_pat_lo}),
        .i_len     (len),
        .i_exact   (r_exact),
        .o_result  (win)
    );

    // one byte's evaluation
    logic                rep1, rep2, cand, ok, before_ok, new_pend;
    logic [15:0]         c1, c2;
    logic [POS_BITS:0]   e1_sum, e2_sum;
    logic [POS_BITS-1:0] e1, e2, s, earliest1, pos_new;
    logic [1:0]          n_res;
    logic [31:0]         line_new;
    logic [LEN_BITS-1:0] seen_new;
    t_res                item1, item2, done_item;
    t_res                slot [3];

    always_comb begin
        rep1      = r_pend_valid && !is_word(r_in_byte) && (r_hits < r_hit_limit);
        e1_sum    = {1'b0, r_pend_start} + (POS_BITS+1)'(len);
        e1        = e1_sum[POS_BITS] ? '1 : e1_sum[POS_BITS-1:0];
        c1        = r_hits + 16'(rep1);
        earliest1 = rep1 ? e1 : r_earliest;

        s    = r_pos - POS_BITS'(len - LEN_BITS'(1));
        cand = (r_in_byte != LINE_FEED)
            && (({1'b0, r_seen} + (LEN_BITS+1)'(1)) >= {1'b0, len})
            && (({1'b0, r_pos} + (POS_BITS+1)'(1)) >= (POS_BITS+1)'(len))
            && win.hit;
        ok        = cand && (s >= earliest1);
        before_ok = (s == '0) || !win.before_is_word;
        new_pend  = ok && r_whole_word && before_ok && !r_in_eot;
        rep2      = ok && (!r_whole_word || (before_ok && r_in_eot)) && (c1 < r_hit_limit);
        e2_sum    = {1'b0, s} + (POS_BITS+1)'(len);
        e2        = e2_sum[POS_BITS] ? '1 : e2_sum[POS_BITS-1:0];
        c2        = c1 + 16'(rep2);

        pos_new  = (&r_pos) ? r_pos : r_pos + POS_BITS'(1);
        line_new = (r_in_byte == LINE_FEED && !(&r_line)) ? r_line + 32'd1 : r_line;
        if (r_in_byte == LINE_FEED) begin
            seen_new = '0;
        end else begin
            seen_new = (&r_seen) ? r_seen : r_seen + LEN_BITS'(1);
        end

        n_res = 2'(rep1) + 2'(rep2) + 2'(r_in_eot);

        item1     = '{KIND_HIT, r_line, 32'(r_pend_start), 32'(e1), c1, 1'b0};
        item2     = '{KIND_HIT, r_line, 32'(s), 32'(e2), c2, 1'b0};
        done_item = '{KIND_DONE, r_line, 32'(pos_new), 32'(pos_new), c2, 1'b0};

        slot[0] = rep1 ? item1 : (rep2 ? item2 : done_item);
        slot[1] = (rep1 && rep2) ? item2 : done_item;
        slot[2] = done_item;
        slot[0].last = (n_res == 2'd1);
        slot[1].last = (n_res == 2'd2);
        slot[2].last = (n_res == 2'd3);
    end

    logic       pop, proceed;
    logic [1:0] cnt_after;
    assign pop       = m_axis_tvalid && m_axis_tready;
    assign cnt_after = r_cnt - 2'(pop);
    assign proceed   = r_in_valid && ((n_res == 2'd0) || (cnt_after == 2'd0));

    assign s_axis_tready = !r_in_valid || proceed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (proceed) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_eot  <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (proceed && r_in_eot)) begin
            r_recent     <= '0;
            r_pos        <= '0;
            r_line       <= 32'd1;
            r_seen       <= '0;
            r_earliest   <= '0;
            r_pend_valid <= 1'b0;
            r_pend_start <= '0;
            r_hits       <= '0;
        end else if (proceed) begin
            r_recent     <= {r_recent[MAX_PAT-2:0], r_in_byte};
            r_pos        <= pos_new;
            r_line       <= line_new;
            r_seen       <= seen_new;
            r_earliest   <= rep2 ? e2 : earliest1;
            r_pend_valid <= new_pend;
            r_pend_start <= s;
            r_hits       <= c2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (proceed && n_res != 2'd0) begin
            r_cnt <= n_res;
        end else if (pop) begin
            r_cnt <= cnt_after;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proceed && n_res != 2'd0) begin
            r_q[0] <= slot[0];
            r_q[1] <= slot[1];
            r_q[2] <= slot[2];
        end else if (pop) begin
            r_q[0] <= r_q[1];
            r_q[1] <= r_q[2];
        end
    end

    assign m_axis_tvalid = (r_cnt != 2'd0);
    assign m_axis_tdata  = {r_q[0].hits, r_q[0].end_off, r_q[0].start_off, r_q[0].line};
    assign m_axis_tuser  = r_q[0].kind;
    assign m_axis_tlast  = r_q[0].last;

    `LASM_ASSERT(a_load_into_empty, !(proceed && n_res != 2'd0) || (cnt_after == 2'd0))
    `LASM_ASSERT(a_done_is_last, !(m_axis_tvalid && m_axis_tuser == KIND_DONE) || m_axis_tlast)
    `LASM_ASSERT(a_hit_counted, !(m_axis_tvalid && m_axis_tuser == KIND_HIT) || (m_axis_tdata[111:96] != 16'd0))
    `LASM_ASSERT_NEXT(a_clear_after_done, proceed && r_in_eot, (r_pos == '0) && (r_hits == '0) && !r_pend_valid)
endmodule
`default_nettype wire
